FILE: sv/iedl_pkg.sv
// Shared types and constants of the impact event detector with log.
`default_nettype none
package iedl_pkg;

   // Item function codes
   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_TOGGLE = 2'd1;
   localparam logic [1:0] FUNC_PREV   = 2'd2;
   localparam logic [1:0] FUNC_NEXT   = 2'd3;

   // Impact grades
   localparam logic [1:0] LEVEL_NONE   = 2'd0;
   localparam logic [1:0] LEVEL_LOW    = 2'd1;
   localparam logic [1:0] LEVEL_MEDIUM = 2'd2;
   localparam logic [1:0] LEVEL_HIGH   = 2'd3;

   // Configuration register indexes (byte address = 4 * index)
   localparam int          CSR_ADDR_W       = 5;
   localparam logic [2:0]  CSR_IDX_BASELINE = 3'd0;
   localparam logic [2:0]  CSR_IDX_IMPACT   = 3'd1;
   localparam logic [2:0]  CSR_IDX_MEDIUM   = 3'd2;
   localparam logic [2:0]  CSR_IDX_HIGH     = 3'd3;
   localparam logic [2:0]  CSR_IDX_COOLDOWN = 3'd4;

   // Register reset values
   localparam logic [15:0] RST_BASELINE = 16'd4096;
   localparam logic [15:0] RST_IMPACT   = 16'd1434;
   localparam logic [15:0] RST_MEDIUM   = 16'd2867;
   localparam logic [15:0] RST_HIGH     = 16'd4915;
   localparam logic [15:0] RST_COOLDOWN = 16'd500;

   localparam int LOG_ENTRY_W = 50;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic        impact;
      logic [1:0]  latest_level;
      logic [15:0] latest_delta;
      logic [31:0] latest_time;
      logic        log_view;
      logic [6:0]  log_count;
      logic [5:0]  view_index;
      logic [1:0]  view_level;
      logic [15:0] view_delta;
      logic [31:0] view_time;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  level;
      logic [15:0] delta;
      logic [31:0] time_ms;
   } log_entry_type;

endpackage
`default_nettype wire

FILE: sv/iedl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module iedl_ram #(
   parameter int WIDTH  = 50,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/iedl_sqrt.sv
// Iterative floor square root of a 32-bit value, one result bit per cycle.
`default_nettype none
module iedl_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] radicand,
   output logic             done,
   output logic [15:0]      root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] bit_ff, bit_in;
   logic [31:0] trial;
   logic        last_step;

   assign trial     = res_ff + bit_ff;
   assign last_step = busy_ff && (bit_ff == 32'd1);

   always_comb begin
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (start) begin
         rem_in = radicand;
         res_in = '0;
         bit_in = 32'h4000_0000;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   assign busy_in = start | (busy_ff & ~last_step);
   assign done_in = last_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[15:0];

endmodule
`default_nettype wire

FILE: sv/impact_event_detector_log.sv
// Impact event detector: magnitude, deviation, grading and event log control.
// A sample passes from its transfer to its result through squaring on one shared
// multiplier, sixteen root steps and the root's done strobe, then decide, log read and
// load. A button item goes straight to decide, log read and load. One item is in work
// at a time; the next transfer is taken the cycle after the result loads, and a result
// waiting in the output register holds only the next result load. Reset clears mode, count,
// pointer and latest values and restores the register defaults; the log memory is not
// cleared, entries are only read once written.
`default_nettype none
module impact_event_detector_log #(
   parameter int LOG_DEPTH = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire iedl_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output iedl_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [iedl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);
   import iedl_pkg::*;

   localparam int CNT_W = $clog2(LOG_DEPTH + 1);
   localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQUARE, ST_ROOT, ST_DECIDE, ST_READ, ST_RESP
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic [15:0] baseline_ff, impact_thr_ff, medium_thr_ff, high_thr_ff, cooldown_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   // Block state
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] ptr_ff;
   logic             mode_ff;
   logic [31:0]      last_hit_ms_ff;
   logic [1:0]       last_level_ff;
   logic [15:0]      last_delta_ff;
   logic [31:0]      last_time_ff;
   logic             hit_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       sq_cnt_ff;

   // Datapath registers
   req_type     item_ff;
   logic [31:0] prod_ff;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] dev_ff, dev_in;
   rsp_type     rsp_data_ff, rsp_in;

   logic signed [15:0] axis_sel;
   logic signed [31:0] square_val;
   logic               sq_start;
   logic [31:0]        radicand;
   logic               sq_done;
   logic [15:0]        root;

   logic             is_sample;
   logic [31:0]      since_ms;
   logic             hit;
   logic [1:0]       level;
   logic             full;
   logic [CNT_W-1:0] count_next;
   logic             can_prev, can_next;
   logic             rsp_free;

   logic             wr_en;
   log_entry_type    wr_entry;
   log_entry_type    rd_entry;
   logic [LOG_ENTRY_W-1:0] rd_raw;

   // ---------------- Configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff   <= RST_BASELINE;
         impact_thr_ff <= RST_IMPACT;
         medium_thr_ff <= RST_MEDIUM;
         high_thr_ff   <= RST_HIGH;
         cooldown_ff   <= RST_COOLDOWN;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IDX_BASELINE: baseline_ff   <= csr_pwdata[15:0];
            CSR_IDX_IMPACT:   impact_thr_ff <= csr_pwdata[15:0];
            CSR_IDX_MEDIUM:   medium_thr_ff <= csr_pwdata[15:0];
            CSR_IDX_HIGH:     high_thr_ff   <= csr_pwdata[15:0];
            CSR_IDX_COOLDOWN: cooldown_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_IDX_BASELINE: csr_prdata = {16'd0, baseline_ff};
         CSR_IDX_IMPACT:   csr_prdata = {16'd0, impact_thr_ff};
         CSR_IDX_MEDIUM:   csr_prdata = {16'd0, medium_thr_ff};
         CSR_IDX_HIGH:     csr_prdata = {16'd0, high_thr_ff};
         CSR_IDX_COOLDOWN: csr_prdata = {16'd0, cooldown_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- Magnitude ----------------
   always_comb begin
      unique case (sq_cnt_ff)
         2'd0:    axis_sel = item_ff.accel_x;
         2'd1:    axis_sel = item_ff.accel_y;
         default: axis_sel = item_ff.accel_z;
      endcase
   end

   assign square_val = axis_sel * axis_sel;
   assign acc_in     = (sq_cnt_ff == 2'd1) ? prod_ff : acc_ff + prod_ff;
   assign sq_start   = (state_ff == ST_SQUARE) && (sq_cnt_ff == 2'd3);
   assign radicand   = acc_ff + prod_ff;
   assign dev_in     = (root >= baseline_ff) ? root - baseline_ff : baseline_ff - root;

   iedl_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (radicand),
      .done     (sq_done),
      .root     (root)
   );

   // ---------------- Decision ----------------
   assign is_sample  = (item_ff.func == FUNC_SAMPLE);
   assign since_ms   = item_ff.now_ms - last_hit_ms_ff;
   assign hit        = is_sample && (dev_ff >= impact_thr_ff)
                       && (since_ms >= {16'd0, cooldown_ff});
   assign full       = (count_ff == CNT_W'(LOG_DEPTH));
   assign count_next = full ? count_ff : count_ff + 1'b1;
   assign can_prev   = (ptr_ff != '0);
   assign can_next   = ((CNT_W'(ptr_ff) + 1'b1) < count_ff);

   always_comb begin
      priority if (dev_ff >= high_thr_ff) begin
         level = LEVEL_HIGH;
      end else if (dev_ff >= medium_thr_ff) begin
         level = LEVEL_MEDIUM;
      end else begin
         level = LEVEL_LOW;
      end
   end

   assign wr_en            = (state_ff == ST_DECIDE) && hit && !full;
   assign wr_entry.level   = level;
   assign wr_entry.delta   = dev_ff;
   assign wr_entry.time_ms = item_ff.now_ms;

   iedl_ram #(
      .WIDTH  (LOG_ENTRY_W),
      .DEPTH  (LOG_DEPTH),
      .ADDR_W (PTR_W)
   ) u_log (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[PTR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (ptr_ff),
      .rd_data (rd_raw)
   );

   assign rd_entry = log_entry_type'(rd_raw);

   // ---------------- Result ----------------
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = ((state_ff == ST_RESP) && rsp_free) || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_in.impact       = hit_ff;
      rsp_in.latest_level = last_level_ff;
      rsp_in.latest_delta = last_delta_ff;
      rsp_in.latest_time  = last_time_ff;
      rsp_in.log_view     = mode_ff;
      rsp_in.log_count    = 7'(count_ff);
      rsp_in.view_index   = 6'(ptr_ff);
      if (count_ff != '0) begin
         rsp_in.view_level = rd_entry.level;
         rsp_in.view_delta = rd_entry.delta;
         rsp_in.view_time  = rd_entry.time_ms;
      end else begin
         rsp_in.view_level = LEVEL_NONE;
         rsp_in.view_delta = '0;
         rsp_in.view_time  = '0;
      end
   end

   // ---------------- Sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sq_cnt_ff      <= '0;
         count_ff       <= '0;
         ptr_ff         <= '0;
         mode_ff        <= 1'b0;
         last_hit_ms_ff <= '0;
         last_level_ff  <= LEVEL_NONE;
         last_delta_ff  <= '0;
         last_time_ff   <= '0;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // load a new result or drop the one transferred
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               sq_cnt_ff <= '0;
               if (req_valid) begin
                  state_ff <= (req_data.func == FUNC_SAMPLE) ? ST_SQUARE : ST_DECIDE;
               end
            end
            ST_SQUARE: begin
               sq_cnt_ff <= sq_cnt_ff + 1'b1;
               if (sq_cnt_ff == 2'd3) begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (sq_done) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               hit_ff <= hit;
               if (hit) begin
                  last_hit_ms_ff <= item_ff.now_ms;
                  last_level_ff  <= level;
                  last_delta_ff  <= dev_ff;
                  last_time_ff   <= item_ff.now_ms;
                  count_ff       <= count_next;
                  ptr_ff         <= PTR_W'(count_next - 1'b1);
               end else if (item_ff.func == FUNC_TOGGLE) begin
                  mode_ff <= ~mode_ff;
               end else if (!is_sample && mode_ff && count_ff != '0) begin
                  if (item_ff.func == FUNC_PREV && can_prev) begin
                     ptr_ff <= ptr_ff - 1'b1;
                  end else if (item_ff.func == FUNC_NEXT && can_next) begin
                     ptr_ff <= ptr_ff + 1'b1;
                  end
               end
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         item_ff <= req_data;
      end
      if (state_ff == ST_SQUARE) begin
         prod_ff <= 32'(square_val);
         if (sq_cnt_ff != 2'd0) begin
            acc_ff <= acc_in;
         end
      end
      if (state_ff == ST_ROOT && sq_done) begin
         dev_ff <= dev_in;
      end
      if (state_ff == ST_RESP && rsp_free) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
